// ===== sv/sdcb_pkg.sv =====
`timescale 1ns / 1ps

package sdcb_pkg;

  // Default ring capacity in frames. It must be a power of two.
  localparam int unsigned CapacityFramesDefault = 1024;

  // Fixed widths of the sample path.
  localparam int unsigned SampleW = 24;
  localparam int unsigned StateW  = 26;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned ProdW   = CoefW + 1 + StateW;
  localparam int unsigned SumW    = 28;

  // Reset value of the pole coefficient, about 0.99786 in unsigned Q0.16.
  localparam logic [CoefW-1:0] PoleCoefReset = 16'd65396;

  // Depth of the queue between the front and back parts. It must be a power of two.
  localparam int unsigned QueueDepth = 2;

  // Command codes on the input channel.
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  // Result status codes. The front part also uses them to classify each item.
  typedef enum logic [1:0] {
    ST_WRITTEN = 2'd0,
    ST_DROPPED = 2'd1,
    ST_READ    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // Classified item as it travels from the front part to the back part.
  typedef struct packed {
    status_e                    op;
    logic signed [SampleW-1:0]  left;
    logic signed [SampleW-1:0]  right;
  } sdcb_item_t;

  // Filter sum x - x_prev + round(R * y_prev / 2^16), rounding half up.
  function automatic logic signed [SumW-1:0] dcb_sum(
      input logic signed [SampleW-1:0] x,
      input logic signed [SampleW-1:0] xp,
      input logic signed [ProdW-1:0]   prod);
    logic signed [ProdW-1:0] rnd;
    logic signed [ProdW-1:0] shf;
    rnd = prod + signed'({{(ProdW-17){1'b0}}, 17'h08000});
    shf = rnd >>> 16;
    return SumW'(x) - SumW'(xp) + signed'(shf[SumW-1:0]);
  endfunction

  // Saturate a filter sum to the stored sample range.
  function automatic logic signed [SampleW-1:0] dcb_sat_sample(
      input logic signed [SumW-1:0] s);
    logic signed [SampleW-1:0] r;
    if (s[SumW-1:SampleW-1] == '0 || s[SumW-1:SampleW-1] == '1) begin
      r = s[SampleW-1:0];
    end else if (s[SumW-1]) begin
      r = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      r = {1'b0, {(SampleW-1){1'b1}}};
    end
    return r;
  endfunction

  // Saturate a filter sum to the feedback state range.
  function automatic logic signed [StateW-1:0] dcb_sat_state(
      input logic signed [SumW-1:0] s);
    logic signed [StateW-1:0] r;
    if (s[SumW-1:StateW-1] == '0 || s[SumW-1:StateW-1] == '1) begin
      r = s[StateW-1:0];
    end else if (s[SumW-1]) begin
      r = {1'b1, {(StateW-1){1'b0}}};
    end else begin
      r = {1'b0, {(StateW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== sv/stereo_dc_blocker_fifo_top.sv =====
`timescale 1ns / 1ps
// Channel  Handshake                 Beat contents
// input    in_valid_i / in_ready_o   cmd_i, left_in_i, right_in_i
// output   out_valid_o / out_ready_i status_o, left_out_o, right_out_o, fill_count_o
// config   cfg_we_i                  cfg_wdata_i (pole coefficient)
//
// A write beat uses the shared filter multiplier for the left channel, then the right;
// read, drop and empty beats do not wait on it, and a beat that follows a write waits
// until that write has reached the ring before it enters the finish stage.
// Reset clears pointers, filter state and all valid flags; the ring needs no clearing.
// Input beats are taken while the two-entry queue has room, so output stalls reach the input once it fills.

module stereo_dc_blocker_fifo_top import sdcb_pkg::*; #(
  parameter int unsigned CapacityFrames = CapacityFramesDefault,
  localparam int unsigned IdxW = $clog2(CapacityFrames),
  localparam int unsigned CntW = IdxW + 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CoefW-1:0]          cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      cmd_i,
  input  logic signed [SampleW-1:0] left_in_i,
  input  logic signed [SampleW-1:0] right_in_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic signed [SampleW-1:0] left_out_o,
  output logic signed [SampleW-1:0] right_out_o,
  output logic [CntW-1:0]           fill_count_o
);

  localparam int unsigned EntryW = $bits(sdcb_item_t) + IdxW + CntW;

  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  sdcb_item_t       f_item;
  logic [IdxW-1:0]  f_addr;
  logic [CntW-1:0]  f_fill;
  logic [EntryW-1:0] q_wdata;
  logic [EntryW-1:0] q_rdata;
  sdcb_item_t       b_item;
  logic [IdxW-1:0]  b_addr;
  logic [CntW-1:0]  b_fill;

  // Front part: accept and classify beats.
  sdcb_front #(
    .CapacityFrames(CapacityFrames)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .left_in_i  (left_in_i),
    .right_in_i (right_in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (f_item),
    .addr_o     (f_addr),
    .fill_o     (f_fill)
  );

  // Queue between the two parts.
  assign q_wdata = {f_item, f_addr, f_fill};
  assign {b_item, b_addr, b_fill} = q_rdata;

  sdcb_queue #(
    .DataW(EntryW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  // Back part: filter, ring access and result register.
  sdcb_back #(
    .CapacityFrames(CapacityFrames)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_valid_i    (q_valid),
    .q_item_i     (b_item),
    .q_addr_i     (b_addr),
    .q_fill_i     (b_fill),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .left_out_o   (left_out_o),
    .right_out_o  (right_out_o),
    .fill_count_o (fill_count_o)
  );

endmodule

// ===== sv/sdcb_front.sv =====
`timescale 1ns / 1ps

module sdcb_front import sdcb_pkg::*; #(
  parameter int unsigned CapacityFrames = CapacityFramesDefault,
  localparam int unsigned IdxW = $clog2(CapacityFrames),
  localparam int unsigned CntW = IdxW + 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      cmd_i,
  input  logic signed [SampleW-1:0] left_in_i,
  input  logic signed [SampleW-1:0] right_in_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output sdcb_item_t                item_o,
  output logic [IdxW-1:0]           addr_o,
  output logic [CntW-1:0]           fill_o
);

  localparam logic [CntW-1:0] FullCnt = CntW'(CapacityFrames);

  logic [CntW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] fill_now;
  logic            accept;

  // A beat is taken whenever the queue has room.
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;
  assign fill_now   = wr_ptr_q - rd_ptr_q;

  // Classify the beat against the ring and advance the matching pointer.
  always_comb begin
    wr_ptr_d     = wr_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    item_o.left  = left_in_i;
    item_o.right = right_in_i;
    addr_o       = wr_ptr_q[IdxW-1:0];
    if (cmd_i == CMD_WRITE) begin
      if (fill_now == FullCnt) begin
        item_o.op = ST_DROPPED;
      end else begin
        item_o.op = ST_WRITTEN;
        wr_ptr_d  = wr_ptr_q + 1'b1;
      end
    end else begin
      addr_o = rd_ptr_q[IdxW-1:0];
      if (fill_now == '0) begin
        item_o.op = ST_EMPTY;
      end else begin
        item_o.op = ST_READ;
        rd_ptr_d  = rd_ptr_q + 1'b1;
      end
    end
    fill_o = wr_ptr_d - rd_ptr_d;
  end

  // Pointers run free modulo twice the capacity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else if (accept) begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

endmodule

// ===== sv/sdcb_queue.sv =====
`timescale 1ns / 1ps

module sdcb_queue import sdcb_pkg::*; #(
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [DataW-1:0] data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam logic [PtrW:0] DepthCnt = (PtrW + 1)'(QueueDepth);

  logic [DataW-1:0] slot_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [PtrW:0]    count_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == DepthCnt);
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Occupancy and pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/sdcb_back.sv =====
`timescale 1ns / 1ps

module sdcb_back import sdcb_pkg::*; #(
  parameter int unsigned CapacityFrames = CapacityFramesDefault,
  localparam int unsigned IdxW = $clog2(CapacityFrames),
  localparam int unsigned CntW = IdxW + 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CoefW-1:0]          cfg_wdata_i,
  input  logic                      q_valid_i,
  input  sdcb_item_t                q_item_i,
  input  logic [IdxW-1:0]           q_addr_i,
  input  logic [CntW-1:0]           q_fill_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic signed [SampleW-1:0] left_out_o,
  output logic signed [SampleW-1:0] right_out_o,
  output logic [CntW-1:0]           fill_count_o
);

  // Configuration and filter state.
  logic [CoefW-1:0]          pole_q;
  logic signed [StateW-1:0]  yp0_q, yp1_q;
  logic signed [SampleW-1:0] xp0_q, xp1_q;

  // Execute stage: multiplier, left channel sum, memory read issue.
  logic                      x_vld_q;
  logic                      x_ph_q;
  sdcb_item_t                x_item_q;
  logic [IdxW-1:0]           x_addr_q;
  logic [CntW-1:0]           x_fill_q;
  logic signed [ProdW-1:0]   prod0_q;

  // Finish stage: right channel sum, memory write, result build.
  logic                      w_vld_q;
  status_e                   w_op_q;
  logic signed [SampleW-1:0] w_left_q;
  logic signed [SampleW-1:0] w_right_q;
  logic signed [ProdW-1:0]   w_prod_q;
  logic [IdxW-1:0]           w_addr_q;
  logic [CntW-1:0]           w_fill_q;
  logic [2*SampleW-1:0]      rd_data_q;

  // Output register.
  logic                      o_vld_q;
  status_e                   o_status_q;
  logic signed [SampleW-1:0] o_left_q;
  logic signed [SampleW-1:0] o_right_q;
  logic [CntW-1:0]           o_fill_q;

  // Frame ring.
  logic [2*SampleW-1:0]      frame_mem_q [CapacityFrames];

  logic                      o_free;
  logic                      w_fire;
  logic                      w_open;
  logic                      x_is_wr;
  logic                      x_go;
  logic                      x_free;
  logic                      x_step;
  logic signed [StateW-1:0]  mult_y;
  logic signed [ProdW-1:0]   mult_p;
  logic signed [SumW-1:0]    sum0;
  logic signed [SumW-1:0]    sum1;

  // Stage flow. An item enters the finish stage only when it holds no write,
  // so the feedback state and the ring are up to date for whatever follows.
  assign o_free  = !o_vld_q || out_ready_i;
  assign w_fire  = w_vld_q && o_free;
  assign w_open  = !w_vld_q || (w_fire && w_op_q != ST_WRITTEN);
  assign x_is_wr = (x_item_q.op == ST_WRITTEN);
  assign x_go    = x_vld_q && (!x_is_wr || x_ph_q) && w_open;
  assign x_step  = x_vld_q && x_is_wr && !x_ph_q;
  assign x_free  = !x_vld_q || x_go;
  assign q_pop_o = q_valid_i && x_free;

  // One multiplier shared by both channels: left in phase zero, right in phase one.
  assign mult_y = x_ph_q ? yp1_q : yp0_q;
  assign mult_p = $signed({1'b0, pole_q}) * mult_y;

  // Filter sums of the two channels.
  assign sum0 = dcb_sum(signed'(x_item_q.left), xp0_q, prod0_q);
  assign sum1 = dcb_sum(w_right_q, xp1_q, w_prod_q);

  // Control state, coefficient and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_q  <= PoleCoefReset;
      yp0_q   <= '0;
      yp1_q   <= '0;
      xp0_q   <= '0;
      xp1_q   <= '0;
      x_vld_q <= 1'b0;
      x_ph_q  <= 1'b0;
      w_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pole_q <= cfg_wdata_i;
      end
      if (q_pop_o) begin
        x_vld_q <= 1'b1;
        x_ph_q  <= 1'b0;
      end else if (x_go) begin
        x_vld_q <= 1'b0;
        x_ph_q  <= 1'b0;
      end else if (x_step) begin
        x_ph_q <= 1'b1;
      end
      if (x_go && x_is_wr) begin
        yp0_q <= dcb_sat_state(sum0);
        xp0_q <= x_item_q.left;
      end
      if (x_go) begin
        w_vld_q <= 1'b1;
      end else if (w_fire) begin
        w_vld_q <= 1'b0;
      end
      if (w_fire && w_op_q == ST_WRITTEN) begin
        yp1_q <= dcb_sat_state(sum1);
        xp1_q <= w_right_q;
      end
      if (w_fire) begin
        o_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        o_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers of the stages.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      x_item_q <= q_item_i;
      x_addr_q <= q_addr_i;
      x_fill_q <= q_fill_i;
    end
    if (x_step) begin
      prod0_q <= mult_p;
    end
    if (x_go) begin
      w_op_q    <= x_item_q.op;
      w_left_q  <= dcb_sat_sample(sum0);
      w_right_q <= x_item_q.right;
      w_prod_q  <= mult_p;
      w_addr_q  <= x_addr_q;
      w_fill_q  <= x_fill_q;
    end
    if (w_fire) begin
      o_status_q <= w_op_q;
      o_fill_q   <= w_fill_q;
      if (w_op_q == ST_READ) begin
        o_left_q  <= rd_data_q[2*SampleW-1:SampleW];
        o_right_q <= rd_data_q[SampleW-1:0];
      end else begin
        o_left_q  <= '0;
        o_right_q <= '0;
      end
    end
  end

  // Ring write from the finish stage.
  always_ff @(posedge clk_i) begin
    if (w_fire && w_op_q == ST_WRITTEN) begin
      frame_mem_q[w_addr_q] <= {w_left_q, dcb_sat_sample(sum1)};
    end
  end

  // Ring read from the execute stage, data registered for the finish stage.
  always_ff @(posedge clk_i) begin
    if (x_go && x_item_q.op == ST_READ) begin
      rd_data_q <= frame_mem_q[x_addr_q];
    end
  end

  assign out_valid_o  = o_vld_q;
  assign status_o     = o_status_q;
  assign left_out_o   = o_left_q;
  assign right_out_o  = o_right_q;
  assign fill_count_o = o_fill_q;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import sdcb_pkg::*;

  localparam int unsigned Cap  = CapacityFramesDefault;
  localparam int unsigned IdxW = $clog2(Cap);
  localparam int unsigned CntW = IdxW + 1;

  localparam int unsigned NumDirected = 17;
  localparam int unsigned QuietLimit  = 300;

  localparam logic signed [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};

  localparam longint StateHi  = (64'sd1 <<< (StateW - 1)) - 1;
  localparam longint StateLo  = -(64'sd1 <<< (StateW - 1));
  localparam longint SampleHi = (64'sd1 <<< (SampleW - 1)) - 1;
  localparam longint SampleLo = -(64'sd1 <<< (SampleW - 1));

  // One result beat as it should appear on the output channel.
  typedef struct packed {
    status_e                   status;
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
    logic [CntW-1:0]           fill;
  } frame_result_t;

  // Answer typed into the directed table; known is low where the predictor decides.
  typedef struct packed {
    bit            known;
    frame_result_t res;
  } answer_t;

  typedef struct packed {
    cmd_e                      cmd;
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
    answer_t                   ans;
  } stim_row_t;

  typedef enum int {
    SEQ_WRITES,
    SEQ_READS,
    SEQ_MIXED,
    SEQ_DC_HOLD
  } seq_kind_e;

  // Clock, reset and block inputs, all known from time zero.
  logic                      clk_i       = 1'b0;
  logic                      rst_n       = 1'b0;
  logic                      cfg_we      = 1'b0;
  logic [CoefW-1:0]          cfg_wdata   = '0;
  logic                      in_valid    = 1'b0;
  cmd_e                      cmd         = CMD_WRITE;
  logic signed [SampleW-1:0] left_in     = '0;
  logic signed [SampleW-1:0] right_in    = '0;
  logic                      out_ready   = 1'b1;

  logic                      in_ready_o;
  logic                      out_valid_o;
  logic [1:0]                status_o;
  logic signed [SampleW-1:0] left_out_o;
  logic signed [SampleW-1:0] right_out_o;
  logic [CntW-1:0]           fill_count_o;

  // Shadow of the block: ring, pointers, filter state and coefficient.
  logic signed [SampleW-1:0] ring_left  [Cap];
  logic signed [SampleW-1:0] ring_right [Cap];
  logic [CntW-1:0]           wr_ptr = '0;
  logic [CntW-1:0]           rd_ptr = '0;
  logic signed [SampleW-1:0] last_x [2];
  logic signed [StateW-1:0]  last_y [2];
  logic [CoefW-1:0]          pole = PoleCoefReset;

  frame_result_t expected_frames [$];
  answer_t       typed_answers [$];

  bit idle_on      = 1'b1;
  int mismatches   = 0;
  int quiet_cycles = 0;
  int beats_sent   = 0;
  int settings     = 1;
  int n_written    = 0;
  int n_dropped    = 0;
  int n_read       = 0;
  int n_empty      = 0;

  // Directed rows: extremes, empty reads and the first write after reset are typed in.
  stim_row_t directed_rows [NumDirected] = '{
    '{CMD_READ,  '0, '0, '{1'b1, '{ST_EMPTY,   '0, '0, CntW'(0)}}},
    '{CMD_WRITE, SampleMax, SampleMin, '{1'b1, '{ST_WRITTEN, '0, '0, CntW'(1)}}},
    '{CMD_READ,  '0, '0, '{1'b1, '{ST_READ, SampleMax, SampleMin, CntW'(0)}}},
    '{CMD_READ,  '0, '0, '{1'b1, '{ST_EMPTY,   '0, '0, CntW'(0)}}},
    '{CMD_WRITE, SampleMin, SampleMax, '0},
    '{CMD_WRITE, SampleMax, SampleMin, '0},
    '{CMD_WRITE, '0, '0, '0},
    '{CMD_WRITE, -24'sd1, 24'sd1, '0},
    '{CMD_WRITE, 24'sh555555, 24'shAAAAAA, '0},
    '{CMD_WRITE, 24'shAAAAAA, 24'sh555555, '0},
    '{CMD_READ,  SampleMax, SampleMax, '0},
    '{CMD_READ,  SampleMin, SampleMin, '0},
    '{CMD_READ,  '0, '0, '0},
    '{CMD_READ,  '0, '0, '0},
    '{CMD_READ,  '0, '0, '0},
    '{CMD_READ,  '0, '0, '0},
    '{CMD_READ,  '0, '0, '{1'b1, '{ST_EMPTY,   '0, '0, CntW'(0)}}}
  };

  stereo_dc_blocker_fifo_top #(
    .CapacityFrames(Cap)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd),
    .left_in_i   (left_in),
    .right_in_i  (right_in),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .status_o    (status_o),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .fill_count_o(fill_count_o)
  );

  // Free-running 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // One-pole DC blocker step for one channel; returns the sample that goes to the ring.
  function automatic logic signed [SampleW-1:0] highpass(input int ch,
                                                         input logic signed [SampleW-1:0] x);
    longint c;
    longint yp;
    longint t;
    longint s;
    c = pole;
    yp = last_y[ch];
    // Round half up, then floor through the arithmetic shift.
    t = (c * yp + 64'sd32768) >>> 16;
    s = longint'(x) - longint'(last_x[ch]) + t;
    last_x[ch] = x;
    last_y[ch] = StateW'(clamp(s, StateLo, StateHi));
    return SampleW'(clamp(s, SampleLo, SampleHi));
  endfunction

  // Advance the shadow ring by one input beat and return the result it causes.
  function automatic frame_result_t predict_frame(input cmd_e c,
                                                  input logic signed [SampleW-1:0] l,
                                                  input logic signed [SampleW-1:0] r);
    frame_result_t e;
    logic [CntW-1:0] used;
    used = wr_ptr - rd_ptr;
    e.left = '0;
    e.right = '0;
    if (c == CMD_WRITE) begin
      if (used == CntW'(Cap)) begin
        e.status = ST_DROPPED;
      end else begin
        ring_left[wr_ptr[IdxW-1:0]] = highpass(0, l);
        ring_right[wr_ptr[IdxW-1:0]] = highpass(1, r);
        wr_ptr = wr_ptr + 1'b1;
        e.status = ST_WRITTEN;
      end
    end else begin
      if (used == '0) begin
        e.status = ST_EMPTY;
      end else begin
        e.left = ring_left[rd_ptr[IdxW-1:0]];
        e.right = ring_right[rd_ptr[IdxW-1:0]];
        rd_ptr = rd_ptr + 1'b1;
        e.status = ST_READ;
      end
    end
    e.fill = wr_ptr - rd_ptr;
    return e;
  endfunction

  // Mostly full-range samples, with extremes and small values mixed in.
  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return SampleMax;
      1: return SampleMin;
      2: return SampleW'(int'($urandom_range(0, 512)) - 256);
      3: return '0;
      default: return SampleW'($urandom);
    endcase
  endfunction

  // Check each result beat against the oldest expectation, then predict each input beat.
  always @(posedge clk_i) begin : scoreboard
    frame_result_t e;
    frame_result_t p;
    answer_t a;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid_o && out_ready) begin
        moved = 1'b1;
        case (status_o)
          ST_WRITTEN: n_written++;
          ST_DROPPED: n_dropped++;
          ST_READ:    n_read++;
          default:    n_empty++;
        endcase
        if (expected_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%t: result beat with nothing expected: status %0d left %0d right %0d fill %0d",
                     $time, status_o, left_out_o, right_out_o, fill_count_o);
          end
        end else begin
          e = expected_frames.pop_front();
          if (status_o !== e.status || left_out_o !== e.left ||
              right_out_o !== e.right || fill_count_o !== e.fill) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%t: expected status %0d left %0d right %0d fill %0d", $time,
                       e.status, e.left, e.right, e.fill);
              $display("%t:   actual status %0d left %0d right %0d fill %0d", $time,
                       status_o, left_out_o, right_out_o, fill_count_o);
            end
          end
        end
      end
      if (in_valid && in_ready_o) begin
        moved = 1'b1;
        p = predict_frame(cmd, left_in, right_in);
        a = typed_answers.pop_front();
        expected_frames.push_back(a.known ? a.res : p);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  // Output stalls come in random bursts while idling is enabled.
  initial begin : out_stalls
    int n;
    @(posedge rst_n);
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk_i);
        out_ready <= 1'b1;
      end
    end
  end

  // Present one input beat, after an optional gap, and hold it until it is taken.
  task automatic send_beat(input cmd_e c, input logic signed [SampleW-1:0] l,
                           input logic signed [SampleW-1:0] r, input answer_t a);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    typed_answers.push_back(a);
    in_valid <= 1'b1;
    cmd <= c;
    left_in <= l;
    right_in <= r;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
  endtask

  // Stop sending and wait until every result beat has come back.
  task automatic drain_results(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_frames.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  // Change the pole coefficient only when the block is idle.
  task automatic set_pole(input logic [CoefW-1:0] v);
    drain_results(6);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    pole = v;
    settings++;
  endtask

  // Random bursts of writes and reads, with held input levels mixed in.
  task automatic random_traffic(input int beats);
    int done;
    int len;
    seq_kind_e kind;
    logic signed [SampleW-1:0] hold_l;
    logic signed [SampleW-1:0] hold_r;
    done = 0;
    while (done < beats) begin
      kind = seq_kind_e'($urandom_range(0, 3));
      case (kind)
        SEQ_WRITES: begin
          len = $urandom_range(1, 24);
          repeat (len) send_beat(CMD_WRITE, pick_sample(), pick_sample(), '0);
        end
        SEQ_READS: begin
          len = $urandom_range(1, 20);
          repeat (len) send_beat(CMD_READ, pick_sample(), pick_sample(), '0);
        end
        SEQ_MIXED: begin
          len = $urandom_range(1, 16);
          repeat (len) send_beat(cmd_e'($urandom_range(0, 1)), pick_sample(), pick_sample(), '0);
        end
        default: begin
          // A held input level, which the filter should bleed away.
          len = $urandom_range(4, 24);
          hold_l = pick_sample();
          hold_r = pick_sample();
          repeat (len) send_beat(CMD_WRITE, hold_l, hold_r, '0);
        end
      endcase
      done += len;
    end
  endtask

  // Reset, directed table, then random phases over several coefficients.
  initial begin : main_flow
    logic [CoefW-1:0] next_pole;
    last_x[0] = '0;
    last_x[1] = '0;
    last_y[0] = '0;
    last_y[1] = '0;
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      send_beat(directed_rows[i].cmd, directed_rows[i].left, directed_rows[i].right,
                directed_rows[i].ans);
    end

    // Phase zero keeps the reset coefficient; the last phase runs without idling.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: next_pole = '0;
        2: next_pole = '1;
        3: next_pole = 16'h8000;
        5: next_pole = 16'd1;
        7: next_pole = PoleCoefReset;
        default: next_pole = CoefW'($urandom);
      endcase
      if (ph == 7) idle_on = 1'b0;
      if (ph > 0) set_pole(next_pole);
      random_traffic(65);
    end

    drain_results(10);
    $display("Sent %0d beats over %0d pole settings: %0d written, %0d dropped, %0d read, %0d empty.",
             beats_sent, settings, n_written, n_dropped, n_read, n_empty);
    $display("Mismatches: %0d, results still outstanding: %0d.", mismatches,
             expected_frames.size());
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("[stereo_dc_blocker_fifo_top] OK");
    end else begin
      $display("[stereo_dc_blocker_fifo_top] ERROR");
    end
    $finish;
  end

  // Watchdog: too many cycles in a row with no beat on either channel.
  initial begin : watchdog
    @(posedge rst_n);
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("Timeout: %0d cycles without a beat, %0d results outstanding.", quiet_cycles,
             expected_frames.size());
    $display("[stereo_dc_blocker_fifo_top] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
sv/sdcb_pkg.sv
sv/sdcb_front.sv
sv/sdcb_queue.sv
sv/sdcb_back.sv
sv/stereo_dc_blocker_fifo_top.sv
dv/testbench.sv
